// ===== rtl/bpa_pkg.sv =====
// shared types, codes and defaults of the bounded positional array
package bpa_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_W          = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    REQ_PUSH_BACK  = 4'd0,
    REQ_PUSH_FRONT = 4'd1,
    REQ_POP_BACK   = 4'd2,
    REQ_POP_FRONT  = 4'd3,
    REQ_INSERT     = 4'd4,
    REQ_REMOVE     = 4'd5,
    REQ_ASSIGN     = 4'd6,
    REQ_READ       = 4'd7,
    REQ_CLEAR      = 4'd8
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [5:0]  position;
    logic [31:0] element_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  element_count;
  } rsp_t;

  // per-cycle move broadcast to every cell
  typedef struct packed {
    logic up;
    logic dn;
    logic wr;
  } cell_op_t;

endpackage

// ===== rtl/bpa_cell.sv =====
// one storage slot of the array with neighbor shift and read select
module bpa_cell #(
  parameter int DATA_WIDTH = bpa_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  bpa_pkg::cell_op_t     op_i,
  input  logic [IDX_W-1:0]      lo_i,
  input  logic [DATA_WIDTH-1:0] val_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [IDX_W-1:0]      sel_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);
  import bpa_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (op_i.up) begin
      if (MY_IDX > lo_i) data_d = left_i;
      else if (MY_IDX == lo_i) data_d = val_i;
    end else if (op_i.dn) begin
      if (MY_IDX >= lo_i) data_d = right_i;
    end else if (op_i.wr && (MY_IDX == lo_i)) begin
      data_d = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (sel_i == MY_IDX) ? data_q : '0;

endmodule

// ===== rtl/bounded_positional_array_core.sv =====
// top level of the bounded positional array: request decode, cell row, read tree
//
// usage
// - request channel: a word on req_i is taken at a rising edge with start_i high
//   and busy_o low; busy_o stays low, so a request may be issued every cycle
// - every request yields one response word on rsp_o, marked by rsp_valid_o for
//   exactly one cycle; the receiver cannot stall, so it must take every strobe
// - response: the response strobe is registered at the accept edge, then at the
//   read-tree register edge; the response word is or-ed straight from the tree
//   registers
// - throughput: one request per cycle; all shifts finish at the accept edge
//   because every cell loads from its neighbor in parallel
// - read path: one-hot cell select, groups of eight or-ed into registers, then
//   the group results or-ed into the response word
// - config channel: cfg_data_i sets the capacity limit when cfg_valid_i and
//   cfg_ready_o are high; ready is always high; write only while idle
// - reset: count goes to zero and capacity to its reset value; cell contents
//   are left undefined since no request can read an unwritten slot
module bounded_positional_array_core #(
  parameter int DEPTH      = bpa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  bpa_pkg::req_t              req_i,
  output logic                       rsp_valid_o,
  output bpa_pkg::rsp_t              rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bpa_pkg::CAP_W-1:0]  cfg_data_i
);
  import bpa_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int GROUP = 8;
  localparam int NG    = (DEPTH + GROUP - 1) / GROUP;
  localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

  // config and count state
  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q;

  // decode
  logic                  acc;
  logic [W-1:0]          cnt_w, pos_w, cap_w, cap_eff, nxt_cnt;
  logic                  full, empty, in_range;
  cell_op_t              op;
  logic [IDX_W-1:0]      lo;
  status_e               st;
  logic                  rd_ok;
  logic [63:0]           val64;
  logic [DATA_WIDTH-1:0] cell_val;

  // stage one and two of the response path
  logic                  v1_q, rd_ok1_q;
  status_e               st1_q;
  logic [6:0]            cnt1_q;
  logic [IDX_W-1:0]      sel_q;
  logic [DATA_WIDTH-1:0] grp_d [NG];
  logic [DATA_WIDTH-1:0] grp_q [NG];
  logic                  rd_ok2_q;
  status_e               st2_q;
  logic [6:0]            cnt2_q;
  logic [DATA_WIDTH-1:0] rd_or;
  logic [63:0]           rd64;
  logic                  vld_q;

  // cell row
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_pad    [NG*GROUP];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // capacity of zero acts as one, above the built depth acts as the depth
  assign cnt_w   = W'(count_q);
  assign pos_w   = W'(req_i.position);
  assign cap_w   = W'(cap_q);
  assign cap_eff = (cap_q == '0) ? W'(1) : ((cap_w > DEPTH_W) ? DEPTH_W : cap_w);
  assign full     = cnt_w >= cap_eff;
  assign empty    = count_q == '0;
  assign in_range = pos_w < cnt_w;

  assign val64    = 64'(req_i.element_value);
  assign cell_val = val64[DATA_WIDTH-1:0];

  // full is checked before empty-range, empty before the index
  always_comb begin
    op      = '0;
    lo      = pos_w[IDX_W-1:0];
    nxt_cnt = cnt_w;
    st      = ST_OK;
    rd_ok   = 1'b0;
    case (req_e'(req_i.req_type))
      REQ_PUSH_BACK: begin
        if (full) st = ST_FULL;
        else begin
          op.wr   = 1'b1;
          lo      = cnt_w[IDX_W-1:0];
          nxt_cnt = cnt_w + W'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) st = ST_FULL;
        else begin
          op.up   = 1'b1;
          lo      = '0;
          nxt_cnt = cnt_w + W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) st = ST_EMPTY;
        else nxt_cnt = cnt_w - W'(1);
      end
      REQ_POP_FRONT: begin
        if (empty) st = ST_EMPTY;
        else begin
          op.dn   = 1'b1;
          lo      = '0;
          nxt_cnt = cnt_w - W'(1);
        end
      end
      REQ_INSERT: begin
        if (full) st = ST_FULL;
        else if (!in_range) st = ST_RANGE;
        else begin
          op.up   = 1'b1;
          nxt_cnt = cnt_w + W'(1);
        end
      end
      REQ_REMOVE: begin
        if (empty) st = ST_EMPTY;
        else if (!in_range) st = ST_RANGE;
        else begin
          op.dn   = 1'b1;
          nxt_cnt = cnt_w - W'(1);
        end
      end
      REQ_ASSIGN: begin
        if (empty) st = ST_EMPTY;
        else if (!in_range) st = ST_RANGE;
        else op.wr = 1'b1;
      end
      REQ_READ: begin
        if (!in_range) st = ST_RANGE;
        else rd_ok = 1'b1;
      end
      REQ_CLEAR: begin
        nxt_cnt = '0;
      end
      default: begin
      end
    endcase
    if (!acc) op = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v1_q    <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      if (acc) count_q <= nxt_cnt[CNT_W-1:0];
      v1_q  <= acc;
      vld_q <= v1_q;
    end
  end

  // stage one metadata rides beside the read tree
  always_ff @(posedge clk_i) begin
    st1_q    <= st;
    cnt1_q   <= 7'(nxt_cnt);
    rd_ok1_q <= rd_ok;
    sel_q    <= pos_w[IDX_W-1:0];
  end

  // row of cells, each loading from its neighbors in parallel
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    bpa_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .lo_i    (lo),
      .val_i   (cell_val),
      .left_i  (left),
      .right_i (right),
      .sel_i   (sel_q),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  for (genvar i = 0; i < NG * GROUP; i++) begin : g_pad
    if (i < DEPTH) begin : g_real
      assign rd_pad[i] = cell_rd[i];
    end else begin : g_zero
      assign rd_pad[i] = '0;
    end
  end

  // first level of the read tree: or of eight selected cells per group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        grp_d[g] = grp_d[g] | rd_pad[g*GROUP+k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NG; g++) begin
      grp_q[g] <= grp_d[g];
    end
  end

  // stage two metadata lines up with the group registers
  always_ff @(posedge clk_i) begin
    st2_q    <= st1_q;
    cnt2_q   <= cnt1_q;
    rd_ok2_q <= rd_ok1_q;
  end

  // second level, passed to the response only for an in-range read
  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NG; g++) begin
      rd_or = rd_or | grp_q[g];
    end
  end

  assign rd64 = 64'(rd_or);

  always_comb begin
    rsp_o.status        = st2_q;
    rsp_o.read_value    = rd_ok2_q ? rd64[31:0] : '0;
    rsp_o.element_count = cnt2_q;
  end

  assign rsp_valid_o = vld_q;

  // a response strobe traces back to a request on start_i
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start_i, 2))
    else $error("response strobe without request");

  // the count never passes the built depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count beyond depth");

  // a rejected request returns no read word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != ST_OK)) |-> (rsp_o.read_value == '0))
    else $error("read word on rejected request");

  // clear empties the array at the accept edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (req_i.req_type == REQ_CLEAR)) |=> (count_q == '0))
    else $error("clear left elements");

endmodule
